### rtl/lcm_pkg.sv
// Package for the lane connection mapper.
// Holds the input and result word types, the plan handed from the balance stage
// to the pair emitter, and the width constants. Depends on nothing.
package lcm_pkg;

  localparam int LANE_W = 4;
  localparam int CNT_W  = LANE_W + 1;
  localparam int POS_W  = LANE_W + 3;

  typedef struct packed {
    logic [LANE_W-1:0] approach_left_pockets;
    logic [LANE_W-1:0] approach_main_lanes;
    logic [LANE_W-1:0] depart_left_pockets;
    logic [LANE_W-1:0] depart_main_lanes;
    logic [LANE_W-1:0] first_approach_lane;
    logic [LANE_W-1:0] last_approach_lane;
    logic [LANE_W-1:0] first_depart_lane;
    logic [LANE_W-1:0] last_depart_lane;
  } lcm_in_t;

  typedef struct packed {
    logic [LANE_W-1:0] in_lane;
    logic              in_through;
    logic [LANE_W-1:0] depart_lane;
    logic              out_through;
    logic              last_pair;
  } lcm_out_t;

  typedef struct packed {
    logic [POS_W-1:0]  a_start;
    logic [POS_W-1:0]  d_start;
    logic [LANE_W-1:0] a_lo;
    logic [LANE_W-1:0] a_hi;
    logic [LANE_W-1:0] d_lo;
    logic [LANE_W-1:0] d_hi;
    logic [CNT_W-1:0]  count;
  } lcm_plan_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic              thru;
  } lcm_lane_t;

endpackage

### rtl/lcm_balance.sv
// Balance logic of the lane connection mapper: orders both lane ranges, works out
// the pair count and the start lane of each side after dropping excess lanes.
// Purely combinational. Depends on lcm_pkg.
module lcm_balance
  import lcm_pkg::*;
(
  input  lcm_in_t   conn,
  output lcm_plan_t plan
);

  logic [LANE_W-1:0]       fi, li, fo, lo;
  logic [CNT_W-1:0]        n_in, n_out, excess;
  logic                    in_big;
  logic [LANE_W-1:0]       b_lo, b_hi, b_left, b_main;
  logic signed [POS_W-1:0] ex_s, room1, s1, rem1, pocket_end, room2, s2, rem2, shift;
  logic signed [POS_W-1:0] fi_s, fo_s;

  always_comb begin
    fi = (conn.first_approach_lane <= conn.last_approach_lane) ?
         conn.first_approach_lane : conn.last_approach_lane;
    li = (conn.first_approach_lane <= conn.last_approach_lane) ?
         conn.last_approach_lane : conn.first_approach_lane;
    fo = (conn.first_depart_lane <= conn.last_depart_lane) ?
         conn.first_depart_lane : conn.last_depart_lane;
    lo = (conn.first_depart_lane <= conn.last_depart_lane) ?
         conn.last_depart_lane : conn.first_depart_lane;

    n_in   = {1'b0, li} - {1'b0, fi} + CNT_W'(1);
    n_out  = {1'b0, lo} - {1'b0, fo} + CNT_W'(1);
    in_big = n_in > n_out;
    excess = in_big ? (n_in - n_out) : (n_out - n_in);

    b_lo   = in_big ? fi : fo;
    b_hi   = in_big ? li : lo;
    b_left = in_big ? conn.approach_left_pockets : conn.depart_left_pockets;
    b_main = in_big ? conn.approach_main_lanes : conn.depart_main_lanes;

    // Excess lanes in left pockets are dropped first and shift the other side.
    ex_s  = $signed({2'b00, excess});
    room1 = $signed({3'b000, b_left}) - $signed({3'b000, b_lo});
    if (room1 < 0) begin
      room1 = '0;
    end
    s1   = (ex_s < room1) ? ex_s : room1;
    rem1 = ex_s - s1;

    // Then lanes beyond the main lanes (right pockets) go without a shift.
    pocket_end = $signed({3'b000, b_left}) + $signed({3'b000, b_main});
    room2      = $signed({3'b000, b_hi}) - pocket_end + POS_W'(1);
    if (room2 < 0) begin
      room2 = '0;
    end
    s2    = (rem1 < room2) ? rem1 : room2;
    rem2  = rem1 - s2;
    shift = s1 + (rem2 >>> 1);

    fi_s = $signed({3'b000, fi});
    fo_s = $signed({3'b000, fo});

    plan.a_start = in_big ? fi_s : (fi_s - shift);
    plan.d_start = in_big ? (fo_s - shift) : fo_s;
    plan.a_lo    = fi;
    plan.a_hi    = li;
    plan.d_lo    = fo;
    plan.d_hi    = lo;
    plan.count   = in_big ? n_in : n_out;
  end

endmodule

### rtl/lane_connection_mapper_core.sv
// Lane connection mapper: registers each connection word, balances the two lane
// ranges and emits one lane pair word per cycle, unless out_ready holds it back,
// through an output register. An accepted word passes the input register, then the
// emitter registers, then the output register. A connection gives max(in, out) pair
// words, at most 16, from the single pair emitter. A new word is taken every cycle
// while the emitter keeps pace. Reset clears all valid flags; no clearing pass.
module lane_connection_mapper_core
  import lcm_pkg::*;
#(
  parameter int MAX_LANES = 16
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lcm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lcm_out_t out_data
);

  logic              a_valid_r;
  lcm_in_t           a_data_r;
  logic              b_valid_r;
  logic [POS_W-1:0]  b_a_r, b_d_r;
  logic [LANE_W-1:0] b_alo_r, b_ahi_r, b_dlo_r, b_dhi_r;
  logic [LANE_W-1:0] b_left_r;
  logic              out_valid_r;
  lcm_out_t          out_data_r;

  lcm_plan_t         plan;
  logic [CNT_W-1:0]  cnt;
  logic              out_load, b_done, b_free, a_move, in_acc;
  lcm_lane_t         a_pick, d_pick;
  lcm_out_t          out_nxt;

  function automatic lcm_lane_t clamp_lane(input logic [POS_W-1:0] v,
                                           input logic [LANE_W-1:0] lo,
                                           input logic [LANE_W-1:0] hi);
    lcm_lane_t r;
    if ($signed(v) < $signed({3'b000, lo})) begin
      r.lane = lo;
      r.thru = 1'b0;
    end else if ($signed(v) > $signed({3'b000, hi})) begin
      r.lane = hi;
      r.thru = 1'b0;
    end else begin
      r.lane = v[LANE_W-1:0];
      r.thru = 1'b1;
    end
    return r;
  endfunction

  lcm_balance u_balance (
    .conn (a_data_r),
    .plan (plan)
  );

  assign cnt      = (int'(plan.count) > MAX_LANES) ? CNT_W'(MAX_LANES) : plan.count;
  assign out_load = b_valid_r && (!out_valid_r || out_ready);
  assign b_done   = out_load && (b_left_r == '0);
  assign b_free   = !b_valid_r || b_done;
  assign a_move   = a_valid_r && b_free;
  assign in_ready = !a_valid_r || a_move;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    a_pick              = clamp_lane(b_a_r, b_alo_r, b_ahi_r);
    d_pick              = clamp_lane(b_d_r, b_dlo_r, b_dhi_r);
    out_nxt.in_lane     = a_pick.lane;
    out_nxt.in_through  = a_pick.thru;
    out_nxt.depart_lane = d_pick.lane;
    out_nxt.out_through = d_pick.thru;
    out_nxt.last_pair   = (b_left_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        b_valid_r <= 1'b1;
      end else if (b_done) begin
        b_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_data_r <= in_data;
    end
    if (a_move) begin
      b_a_r    <= plan.a_start;
      b_d_r    <= plan.d_start;
      b_alo_r  <= plan.a_lo;
      b_ahi_r  <= plan.a_hi;
      b_dlo_r  <= plan.d_lo;
      b_dhi_r  <= plan.d_hi;
      b_left_r <= LANE_W'(cnt - CNT_W'(1));
    end else if (out_load) begin
      b_a_r    <= b_a_r + POS_W'(1);
      b_d_r    <= b_d_r + POS_W'(1);
      b_left_r <= b_left_r - LANE_W'(1);
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // A pair is always complete on at least one side, since the wider range is walked whole.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.in_through || out_data_r.out_through))
    else $error("pair word with neither lane inside its range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("emitted pair word was lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_load && !a_move) |=> ($stable(b_left_r) && $stable(b_a_r)))
    else $error("emitter advanced without emitting a pair word");

  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_free) |=> (a_valid_r && $stable(a_data_r)))
    else $error("input register changed while the emitter was busy");
`endif

endmodule
